/* rtl/core/fgcr_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the glyph column renderer.
package fgcr_pkg;

  localparam int STORE_BYTES     = 4096;
  localparam int ADDR_W          = $clog2(STORE_BYTES);
  localparam int SCREEN_COLUMNS  = 128;
  localparam int SCREEN_ROWS     = 128;
  localparam int MAX_GLYPH_WIDTH = 32;
  localparam int MAX_HEIGHT      = 32;
  // wide enough for a screen coordinate plus a glyph offset
  localparam int POS_W           = 11;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 80;

  localparam logic [7:0] SPACE_CODE = 8'd32;
  localparam logic [7:0] N_CODE     = 8'd110;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHAR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IS_FIXED_FONT = 3'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam logic [1:0] ST_DRAWN       = 2'd0;
  localparam logic [1:0] ST_NOT_IN_FONT = 2'd1;
  localparam logic [1:0] ST_OFF_SCREEN  = 2'd2;
  localparam logic [1:0] ST_SPACE       = 2'd3;

  typedef struct packed {
    logic capture;     // latch the draw fields of an accepted item
    logic write;       // write the load byte into the font store
    logic classify;    // decide status, width and visibility
    logic take_width;  // take the width table byte just read
    logic mul;         // fixed font: glyph index times width
    logic step;        // one step of the read run (sum or column bytes)
    logic step_bytes;  // run reads column bytes rather than table widths
    logic start;       // form the glyph start address
    logic col_begin;   // open a new column
    logic emit_col;    // load a column result into the output register
    logic emit_final;  // load the final result into the output register
  } cmd_t;

  typedef struct packed {
    logic early_final;
    logic fixed;
    logic space;
    logic drawn;
    logic run_done;
    logic col_end;
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/fgcr_ctrl.sv */
// Sequencer for load and draw items of the glyph column renderer.
module fgcr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_op,
  input  fgcr_pkg::stat_t stat,
  output logic           in_tready,
  output fgcr_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_WWAIT = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_START = 4'd5;
  localparam logic [3:0] S_COL   = 4'd6;
  localparam logic [3:0] S_BYTES = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_FINAL = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          if (in_op == fgcr_pkg::OP_LOAD) begin
            cmd.write = 1'b1;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd.classify = 1'b1;
        if (stat.early_final) begin
          state_nxt = S_FINAL;
        end else if (!stat.fixed) begin
          state_nxt = S_WWAIT;
        end else if (stat.space) begin
          state_nxt = S_COL;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_WWAIT: begin
        cmd.take_width = 1'b1;
        state_nxt = stat.space ? S_COL : S_SUM;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_START;
      end
      S_SUM: begin
        cmd.step = 1'b1;
        if (stat.run_done) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_COL;
      end
      S_COL: begin
        cmd.col_begin = 1'b1;
        if (stat.col_end) begin
          state_nxt = S_FINAL;
        end else if (stat.drawn) begin
          state_nxt = S_BYTES;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_BYTES: begin
        cmd.step       = 1'b1;
        cmd.step_bytes = 1'b1;
        if (stat.run_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_col = 1'b1;
          state_nxt    = S_COL;
        end
      end
      S_FINAL: begin
        if (stat.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/fgcr_dp.sv */
// Datapath: configuration registers, font store, address arithmetic and output register.
module fgcr_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fgcr_pkg::cmd_t                      cmd,
  output fgcr_pkg::stat_t                     stat,
  input  logic                               cfg_we,
  input  logic [fgcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fgcr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [fgcr_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [6:0]                         out_column_x,
  output logic [31:0]                        out_pixel_bits,
  output logic [31:0]                        out_row_visible,
  output logic [5:0]                         out_char_width,
  output logic [1:0]                         out_status,
  output logic                               out_last
);

  localparam int AW = fgcr_pkg::ADDR_W;
  localparam int PW = fgcr_pkg::POS_W;

  // configuration
  logic [7:0] first_char_r;
  logic [7:0] char_count_r;
  logic [5:0] fixed_width_r;
  logic [5:0] glyph_height_r;
  logic       is_fixed_r;

  // captured draw fields
  logic [7:0] letter_r;
  logic [7:0] pos_x_r;
  logic [7:0] pos_y_r;

  // draw working state
  logic [1:0]    status_r;
  logic [7:0]    width_r;
  logic [7:0]    idx_r;
  logic [31:0]   vis_r;
  logic [5:0]    ox_r;
  logic [7:0]    cnt_r;
  logic          pend_r;
  logic [AW-1:0] sum_r;
  logic [AW-1:0] start_r;
  logic [AW-1:0] baddr_r;
  logic [31:0]   bits_r;

  // font store
  logic [7:0]    mem [fgcr_pkg::STORE_BYTES];
  logic [7:0]    rdata_r;
  logic [AW-1:0] rd_addr;

  logic          out_valid_r;

  logic [5:0]    h;
  logic [2:0]    nbytes;
  logic          space;
  logic [7:0]    code;
  logic          code_in;
  logic          off;
  logic [7:0]    code_idx;
  logic [5:0]    shown;
  logic [7:0]    run_limit;
  logic          run_issue;
  logic [31:0]   vis_nxt;
  logic [1:0]    status_nxt;
  logic [1:0]    acc_j;
  logic          early_final;

  // map one stored byte of byte row j onto glyph rows
  function automatic logic [31:0] byte_rows(input logic [7:0] b, input logic [1:0] j,
                                            input logic [5:0] hh, input logic [2:0] nb);
    logic [4:0]  sh;
    logic [31:0] m;
    logic [6:0]  lo;
    lo = {2'b00, j, 3'b000};
    // last byte row of a tall glyph is bottom aligned
    if (nb > 3'd1 && {1'b0, j} == nb - 3'd1) begin
      sh = 5'(hh - 6'd8);
    end else begin
      sh = lo[4:0];
    end
    for (int r = 0; r < 32; r++) begin
      m[r] = (7'(r) >= lo) && (7'(r) < {1'b0, hh}) && (7'(r) < lo + 7'd8);
    end
    return (32'(b) << sh) & m;
  endfunction

  always_comb begin
    h = (glyph_height_r > 6'(fgcr_pkg::MAX_HEIGHT)) ? 6'(fgcr_pkg::MAX_HEIGHT)
                                                     : glyph_height_r;
    nbytes   = 3'((7'(h) + 7'd7) >> 3);
    space    = (letter_r == fgcr_pkg::SPACE_CODE);
    code     = space ? fgcr_pkg::N_CODE : letter_r;
    code_in  = (code >= first_char_r) &&
               ({1'b0, code} < {1'b0, first_char_r} + {1'b0, char_count_r});
    off      = (PW'(pos_x_r) >= PW'(fgcr_pkg::SCREEN_COLUMNS)) ||
               (PW'(pos_y_r) >= PW'(fgcr_pkg::SCREEN_ROWS));
    code_idx = code - first_char_r;
    shown    = (width_r > 8'(fgcr_pkg::MAX_GLYPH_WIDTH)) ? 6'(fgcr_pkg::MAX_GLYPH_WIDTH)
                                                          : width_r[5:0];
    early_final = off || !code_in;

    priority if (off) begin
      status_nxt = fgcr_pkg::ST_OFF_SCREEN;
    end else if (space) begin
      status_nxt = fgcr_pkg::ST_SPACE;
    end else if (!code_in) begin
      status_nxt = fgcr_pkg::ST_NOT_IN_FONT;
    end else begin
      status_nxt = fgcr_pkg::ST_DRAWN;
    end

    for (int r = 0; r < 32; r++) begin
      vis_nxt[r] = (6'(r) < h) &&
                   (PW'(pos_y_r) + PW'(r) < PW'(fgcr_pkg::SCREEN_ROWS));
    end

    run_limit = cmd.step_bytes ? 8'(nbytes) : idx_r;
    run_issue = cmd.step && (cnt_r != run_limit);
    acc_j     = 2'(cnt_r - 8'd1);

    if (run_issue) begin
      rd_addr = cmd.step_bytes ? baddr_r : AW'(cnt_r);
    end else begin
      rd_addr = AW'(code_idx);
    end

    stat.early_final = early_final;
    stat.fixed       = is_fixed_r;
    stat.space       = space;
    stat.drawn       = (status_r == fgcr_pkg::ST_DRAWN);
    stat.run_done    = (cnt_r == run_limit) && !pend_r;
    stat.col_end     = (ox_r >= shown) ||
                       (PW'(pos_x_r) + PW'(ox_r) >= PW'(fgcr_pkg::SCREEN_COLUMNS));
    stat.out_free    = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_char_r   <= 8'd32;
      char_count_r   <= 8'd96;
      fixed_width_r  <= 6'd5;
      glyph_height_r <= 6'd7;
      is_fixed_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fgcr_pkg::REG_FIRST_CHAR:    first_char_r   <= cfg_data;
        fgcr_pkg::REG_CHAR_COUNT:    char_count_r   <= cfg_data;
        fgcr_pkg::REG_FIXED_WIDTH:   fixed_width_r  <= cfg_data[5:0];
        fgcr_pkg::REG_GLYPH_HEIGHT:  glyph_height_r <= cfg_data[5:0];
        fgcr_pkg::REG_IS_FIXED_FONT: is_fixed_r     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[AW'(in_tdata[11:0])] <= in_tdata[19:12];
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      letter_r <= in_tdata[27:20];
      pos_x_r  <= in_tdata[35:28];
      pos_y_r  <= in_tdata[43:36];
    end

    if (cmd.classify) begin
      status_r <= status_nxt;
      width_r  <= (!early_final && is_fixed_r) ? 8'(fixed_width_r) : 8'd0;
      idx_r    <= code_idx;
      vis_r    <= vis_nxt;
    end else if (cmd.take_width) begin
      width_r  <= rdata_r;
    end

    if (cmd.classify) begin
      ox_r <= '0;
    end else if (cmd.emit_col) begin
      ox_r <= ox_r + 6'd1;
    end

    if (cmd.mul) begin
      sum_r <= AW'(14'(idx_r) * 14'(fixed_width_r));
    end else if (cmd.take_width) begin
      sum_r <= '0;
    end else if (cmd.step && !cmd.step_bytes && pend_r) begin
      sum_r <= sum_r + AW'(rdata_r);
    end

    if (cmd.start) begin
      start_r <= (is_fixed_r ? '0 : AW'(char_count_r)) + AW'(sum_r * AW'(nbytes));
    end

    if (cmd.col_begin) begin
      bits_r  <= '0;
      baddr_r <= start_r + AW'(ox_r);
    end else if (cmd.step && cmd.step_bytes) begin
      if (run_issue) begin
        baddr_r <= baddr_r + AW'(width_r);
      end
      if (pend_r) begin
        bits_r <= bits_r | byte_rows(rdata_r, acc_j, h, nbytes);
      end
    end

    // read run: issue one read a cycle, fold in its data in the following cycle
    if (cmd.take_width || cmd.col_begin) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.step) begin
      if (run_issue) begin
        cnt_r  <= cnt_r + 8'd1;
        pend_r <= 1'b1;
      end else begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_col || cmd.emit_final) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_col) begin
      out_column_x    <= 7'(pos_x_r + 8'(ox_r));
      out_pixel_bits  <= bits_r;
      out_row_visible <= vis_r;
      out_char_width  <= '0;
      out_status      <= status_r;
      out_last        <= 1'b0;
    end else if (cmd.emit_final) begin
      out_column_x    <= '0;
      out_pixel_bits  <= '0;
      out_row_visible <= '0;
      out_char_width  <= shown;
      out_status      <= status_r;
      out_last        <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

/* rtl/core/font_glyph_column_renderer_top.sv */
// A load item writes its byte into the font store when it is accepted. A draw item is
// classified, then finds its glyph start by a multiply (fixed font) or by summing width table
// bytes on the one store read port (variable font); per column it reads the byte rows of a
// drawn glyph and loads a column result, then loads the final result. Off-screen or missing
// characters skip straight to it. The next item is taken once the final result is loaded.
// Reset (rst_n low, synchronous) restores config defaults and empties the output register.
module font_glyph_column_renderer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // load_address[11:0], load_byte[19:12], letter[27:20], pos_x[35:28], pos_y[43:36]
  input  logic [fgcr_pkg::IN_DATA_W-1:0]     in_tdata,
  // op[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // column_x[6:0], pixel_bits[38:7], row_visible[70:39], char_width[76:71]
  output logic [fgcr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status[1:0]
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fgcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fgcr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  fgcr_pkg::cmd_t  cmd;
  fgcr_pkg::stat_t stat;

  logic [6:0]  column_x;
  logic [31:0] pixel_bits;
  logic [31:0] row_visible;
  logic [5:0]  char_width;

  assign cfg_ready = 1'b1;

  fgcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  fgcr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_tdata        (in_tdata),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_column_x    (column_x),
    .out_pixel_bits  (pixel_bits),
    .out_row_visible (row_visible),
    .out_char_width  (char_width),
    .out_status      (out_tuser),
    .out_last        (out_tlast)
  );

  assign out_tdata = {3'b000, char_width, row_visible, pixel_bits, column_x};

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the glyph column renderer: font loads, draws and result checks.
`timescale 1ns / 100ps

module tb_top;
  import fgcr_pkg::*;

  typedef struct packed {
    logic [6:0]  col_x;
    logic [31:0] bits;
    logic [31:0] vis;
    logic [5:0]  width;
    logic [1:0]  status;
    logic        last;
  } column_rec_t;

  class glyph_scoreboard;
    logic [7:0]        font_mem [STORE_BYTES];
    bit                filled   [STORE_BYTES];
    int unsigned       first_code, code_count, mono_width, rows_cfg;
    bit                mono;
    int                miss_addr;
    int                errors;
    column_rec_t       pending_cols[$];

    function new();
      first_code = 32;
      code_count = 96;
      mono_width = 5;
      rows_cfg   = 7;
      mono       = 1'b1;
      errors     = 0;
      foreach (filled[i]) begin
        filled[i]   = 1'b0;
        font_mem[i] = 8'h00;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_FIRST_CHAR:    first_code = value;
        REG_CHAR_COUNT:    code_count = value;
        REG_FIXED_WIDTH:   mono_width = value & 8'h3F;
        REG_GLYPH_HEIGHT:  rows_cfg   = value & 8'h3F;
        REG_IS_FIXED_FONT: mono       = value[0];
        default: ;
      endcase
    endfunction

    // Store read; remember the first address that was never loaded.
    function int unsigned fetch(int unsigned addr);
      int unsigned a = addr % STORE_BYTES;
      if (!filled[a] && miss_addr < 0) miss_addr = a;
      return font_mem[a];
    endfunction

    function bit has_code(int unsigned code);
      return code >= first_code && code < first_code + code_count;
    endfunction

    function int unsigned width_of(int unsigned code);
      return mono ? mono_width : fetch(code - first_code);
    endfunction

    function column_rec_t closing_rec(int unsigned shown, logic [1:0] st);
      column_rec_t rec;
      rec = '0;
      rec.width  = 6'(shown);
      rec.status = st;
      rec.last   = 1'b1;
      return rec;
    endfunction

    function void render_glyph(logic [7:0] letter, logic [7:0] px, logic [7:0] py,
                               ref column_rec_t res[$]);
      int unsigned h, nb, wid, shown, base, sum, vis, bits, b, j, ox, r;
      logic [1:0]  st;
      column_rec_t rec;
      if (px >= SCREEN_COLUMNS || py >= SCREEN_ROWS) begin
        res.push_back(closing_rec(0, ST_OFF_SCREEN));
        return;
      end
      h    = rows_cfg > MAX_HEIGHT ? MAX_HEIGHT : rows_cfg;
      nb   = (h + 7) / 8;
      base = 0;
      if (letter == SPACE_CODE) begin
        st  = ST_SPACE;
        wid = has_code(N_CODE) ? width_of(N_CODE) : 0;
      end else if (!has_code(letter)) begin
        res.push_back(closing_rec(0, ST_NOT_IN_FONT));
        return;
      end else begin
        st  = ST_DRAWN;
        wid = width_of(letter);
        if (mono) begin
          base = (letter - first_code) * nb * wid;
        end else begin
          // variable font: glyph follows the table and all earlier glyphs
          sum = 0;
          for (int unsigned i = 0; i < letter - first_code; i++) sum += fetch(i);
          base = code_count + sum * nb;
        end
      end
      shown = wid > MAX_GLYPH_WIDTH ? MAX_GLYPH_WIDTH : wid;
      vis = 0;
      for (r = 0; r < h; r++)
        if (py + r < SCREEN_ROWS) vis |= 32'd1 << r;
      for (ox = 0; ox < shown && px + ox < SCREEN_COLUMNS; ox++) begin
        bits = 0;
        if (st == ST_DRAWN) begin
          for (r = 0; r < h; r++) begin
            j = r / 8;
            // last byte row of a tall glyph is bottom-aligned
            b = (nb > 1 && j == nb - 1) ? r + 8 - h : r % 8;
            if (((fetch(base + ox + j * wid) >> b) & 1) != 0) bits |= 32'd1 << r;
          end
        end
        rec        = '0;
        rec.col_x  = 7'(px + ox);
        rec.bits   = bits;
        rec.vis    = vis;
        rec.status = st;
        res.push_back(rec);
      end
      res.push_back(closing_rec(shown, st));
    endfunction

    function int missing_byte(logic [7:0] letter, logic [7:0] px, logic [7:0] py);
      column_rec_t scratch[$];
      miss_addr = -1;
      render_glyph(letter, px, py, scratch);
      return miss_addr;
    endfunction

    function void note_item(logic op, logic [IN_DATA_W-1:0] data);
      if (op == OP_LOAD) begin
        font_mem[data[11:0]] = data[19:12];
        filled[data[11:0]]   = 1'b1;
      end else begin
        render_glyph(data[27:20], data[35:28], data[43:36], pending_cols);
      end
    endfunction

    function string describe(column_rec_t rec);
      return $sformatf("x=%0d bits=%h vis=%h w=%0d st=%0d last=%0b",
                       rec.col_x, rec.bits, rec.vis, rec.width, rec.status, rec.last);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(column_rec_t got);
      column_rec_t want;
      if (pending_cols.size() == 0) begin
        flag({"unexpected result ", describe(got)});
        return;
      end
      want = pending_cols.pop_front();
      if (got.col_x !== want.col_x || got.bits !== want.bits || got.vis !== want.vis ||
          got.width !== want.width || got.status !== want.status || got.last !== want.last)
        flag({"result mismatch: expected ", describe(want), ", got ", describe(got)});
    endfunction

    function int pending();
      return pending_cols.size();
    endfunction
  endclass

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata   = '0;
  logic                    in_tuser   = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic [1:0]              out_tuser;
  logic                    out_tlast;
  logic                    cfg_valid  = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_DATA_W-1:0]   cfg_data   = '0;

  glyph_scoreboard sb;
  int              steady_left = 0;
  // every accepted item, font fill loads included
  int              items_sent  = 0;

  font_glyph_column_renderer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_pos();
    int r = $urandom_range(0, 29);
    if (r == 0) return 8'($urandom_range(128, 255));
    if (r < 4) return 8'($urandom_range(110, 127));
    return 8'($urandom_range(0, 127));
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tdata[6:0], out_tdata[38:7], out_tdata[70:39],
                       out_tdata[76:71], out_tuser, out_tlast});
  end

  initial begin : sink_pace
    int stall;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 150 : 12)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic op, input logic [IN_DATA_W-1:0] data);
    int gap;
    gap = (steady_left > 0) ? 0 : pick_gap();
    if (steady_left > 0) steady_left--;
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, data);
    items_sent++;
  endtask

  task automatic load_font_byte(input logic [11:0] addr, input logic [7:0] value);
    send_item(OP_LOAD, {4'b0, 8'($urandom), 8'($urandom), 8'($urandom), value, addr});
  endtask

  // Width table entries stay mostly narrow; bitmap bytes are random.
  function automatic logic [7:0] fill_value(int addr);
    int r;
    if (sb.mono || addr >= sb.code_count) return 8'($urandom);
    r = $urandom_range(0, 19);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'($urandom_range(30, 48));
    return 8'($urandom_range(1, 8));
  endfunction

  // Load every byte the draw will read before sending it.
  task automatic draw_glyph(input logic [7:0] letter, input logic [7:0] px,
                            input logic [7:0] py);
    int addr;
    addr = sb.missing_byte(letter, px, py);
    while (addr >= 0) begin
      load_font_byte(addr[11:0], fill_value(addr));
      addr = sb.missing_byte(letter, px, py);
    end
    send_item(OP_DRAW, {4'b0, py, px, letter, 8'($urandom), 12'($urandom)});
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
  endtask

  task automatic setup_font(input int first, input int count, input int wid,
                            input int height, input bit fixed);
    settle();
    write_reg(REG_FIRST_CHAR, 8'(first));
    write_reg(REG_CHAR_COUNT, 8'(count));
    write_reg(REG_FIXED_WIDTH, 8'(wid));
    write_reg(REG_GLYPH_HEIGHT, 8'(height));
    write_reg(REG_IS_FIXED_FONT, 8'(fixed));
    cfg_valid <= 1'b0;
  endtask

  // Send items until about count of them, fill loads included, have gone in.
  task automatic random_items(input int count);
    int          kind, hi, stop_at;
    logic [7:0]  letter;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 29) == 0) steady_left = 25;
      kind = $urandom_range(0, 99);
      hi   = sb.first_code + sb.code_count - 1;
      if (hi > 255) hi = 255;
      if (kind < 10) begin
        load_font_byte(12'($urandom), 8'($urandom));
      end else begin
        if (kind < 20) letter = SPACE_CODE;
        else if (kind < 30 || sb.code_count == 0) letter = 8'($urandom);
        else letter = 8'($urandom_range(sb.first_code, hi));
        draw_glyph(letter, pick_pos(), pick_pos());
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: edges of the screen and the font range on the reset font.
    draw_glyph(8'd65, 8'd0, 8'd0);
    draw_glyph(8'd33, 8'd127, 8'd127);
    draw_glyph(8'd127, 8'd124, 8'd121);
    draw_glyph(8'd128, 8'd5, 8'd5);
    draw_glyph(8'd31, 8'd5, 8'd5);
    draw_glyph(8'd0, 8'd0, 8'd0);
    draw_glyph(8'd255, 8'd127, 8'd127);
    draw_glyph(SPACE_CODE, 8'd60, 8'd60);
    draw_glyph(SPACE_CODE, 8'd126, 8'd0);
    draw_glyph(8'd65, 8'd128, 8'd0);
    draw_glyph(8'd65, 8'd0, 8'd128);
    draw_glyph(8'd65, 8'd255, 8'd255);
    load_font_byte(12'hFFF, 8'hFF);
    load_font_byte(12'h000, 8'h00);
    draw_glyph(8'd33, 8'd3, 8'd40);
    draw_glyph(N_CODE, 8'd64, 8'd100);

    setup_font(32, 96, 5, 7, 0);     // same range, width table
    random_items(25);
    setup_font(0, 255, 32, 32, 1);   // widest and tallest glyphs
    random_items(10);
    setup_font(200, 255, 8, 1, 0);   // top codes only, no 'n' for a space
    random_items(25);
    setup_font(65, 0, 0, 16, 1);     // empty font
    random_items(15);
    setup_font(48, 80, 40, 12, 1);   // stored width past the column limit
    random_items(15);
    setup_font(0, 128, 3, 24, 0);
    random_items(30);
    setup_font(33, 90, 3, 40, 1);    // height past the row limit
    random_items(20);
    setup_font(32, 96, 6, 0, 0);     // no rows at all
    random_items(20);
    repeat (4) begin
      setup_font($urandom_range(0, 1) ? 32 : $urandom_range(0, 255),
                 $urandom_range(0, 255),
                 ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(1, 8),
                 ($urandom_range(0, 7) == 0) ? $urandom_range(17, 32) : $urandom_range(1, 16),
                 $urandom_range(0, 1));
      random_items(12);
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
